// ===== rtl/double_ended_queue_core_defines.svh =====
// assertion macros for the double-ended queue core
// no dependencies; included by the top level only
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dq assertion failed");

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dq assertion failed");

`endif

// ===== rtl/dq_pkg.sv =====
// shared types and codes for the double-ended queue core
// no dependencies
package dq_pkg;

    // request codes
    localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
    localparam logic [1:0] FN_PUSH_REAR  = 2'd1;
    localparam logic [1:0] FN_POP_FRONT  = 2'd2;
    localparam logic [1:0] FN_POP_REAR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [WORD_W-1:0] value;
    } t_dq_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [1:0]               status;
    } t_dq_out_item;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic [1:0] status;
    } t_dq_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic fill_one;
        logic fill_last;
    } t_dq_stat;

endpackage

// ===== rtl/dq_ctrl.sv =====
// occupancy state machine and request decode for the double-ended queue
// depends on dq_pkg
module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_func,
    input  dq_pkg::t_dq_stat i_stat,
    output logic             o_in_ready,
    output dq_pkg::t_dq_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_EMPTY = 3'b001,
        S_PART  = 3'b010,
        S_FULL  = 3'b100
    } t_occ_state;

    t_occ_state r_state, n_state;
    logic       w_accept;
    logic       w_is_push;
    logic       w_push_ok;
    logic       w_pop_ok;

    assign o_in_ready = i_stat.out_free;
    assign w_accept   = i_in_valid && i_stat.out_free;
    assign w_is_push  = (i_func == dq_pkg::FN_PUSH_FRONT) || (i_func == dq_pkg::FN_PUSH_REAR);
    assign w_push_ok  = w_accept && w_is_push && (r_state != S_FULL);
    assign w_pop_ok   = w_accept && !w_is_push && (r_state != S_EMPTY);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = w_accept;
        o_cmd.push_front = w_push_ok && (i_func == dq_pkg::FN_PUSH_FRONT);
        o_cmd.push_rear  = w_push_ok && (i_func == dq_pkg::FN_PUSH_REAR);
        o_cmd.pop_front  = w_pop_ok && (i_func == dq_pkg::FN_POP_FRONT);
        o_cmd.pop_rear   = w_pop_ok && (i_func == dq_pkg::FN_POP_REAR);
        if (w_is_push && (r_state == S_FULL)) begin
            o_cmd.status = dq_pkg::ST_FULL;
        end else if (!w_is_push && (r_state == S_EMPTY)) begin
            o_cmd.status = dq_pkg::ST_EMPTY;
        end else begin
            o_cmd.status = dq_pkg::ST_DONE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: begin
                if (w_push_ok) begin
                    n_state = S_PART;
                end
            end
            S_PART: begin
                if (w_push_ok && i_stat.fill_last) begin
                    n_state = S_FULL;
                end else if (w_pop_ok && i_stat.fill_one) begin
                    n_state = S_EMPTY;
                end
            end
            S_FULL: begin
                if (w_pop_ok) begin
                    n_state = S_PART;
                end
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dq_datapath.sv =====
// storage, head pointer, fill count and result register of the queue
// depends on dq_pkg
module dq_datapath #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dq_pkg::t_dq_cmd      i_cmd,
    input  logic signed [dq_pkg::WORD_W-1:0] i_value,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output dq_pkg::t_dq_out_item o_out_item,
    output dq_pkg::t_dq_stat     o_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned OW = (DATA_WIDTH < dq_pkg::WORD_W) ? DATA_WIDTH : dq_pkg::WORD_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_out_valid;
    dq_pkg::t_dq_out_item r_out_item;

    logic [AW-1:0] w_head_dec;
    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] w_rear_off;
    logic [AW:0]   w_rear_sum;
    logic [AW-1:0] w_rear_slot;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en;
    logic          w_rd_en;

    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // rear slot: head + fill on push, head + fill - 1 on pop, wrapped once
    assign w_rear_off  = i_cmd.pop_rear ? AW'(r_fill - CW'(1)) : AW'(r_fill);
    assign w_rear_sum  = {1'b0, r_head} + {1'b0, w_rear_off};
    assign w_rear_slot = (w_rear_sum >= (AW + 1)'(DEPTH)) ? AW'(w_rear_sum - (AW + 1)'(DEPTH))
                                                           : AW'(w_rear_sum);

    assign w_wr_en   = i_cmd.push_front || i_cmd.push_rear;
    assign w_wr_addr = i_cmd.push_front ? w_head_dec : w_rear_slot;
    assign w_rd_en   = i_cmd.pop_front || i_cmd.pop_rear;
    assign w_rd_addr = i_cmd.pop_front ? r_head : w_rear_slot;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.push_front) begin
            n_head = w_head_dec;
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.push_rear) begin
            n_fill = r_fill + CW'(1);
        end else if (i_cmd.pop_front) begin
            n_head = w_head_inc;
            n_fill = r_fill - CW'(1);
        end else if (i_cmd.pop_rear) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= DATA_WIDTH'(i_value);
        end
    end

    // registered read straight into the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.status <= i_cmd.status;
            if (w_rd_en) begin
                r_out_item.pop_value <= dq_pkg::WORD_W'(mem[w_rd_addr][OW-1:0]);
            end else begin
                r_out_item.pop_value <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.fill_one  = (r_fill == CW'(1));
    assign o_stat.fill_last = (r_fill == CW'(DEPTH - 1));

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// double-ended queue core: the result is registered at the accept edge
// throughput one transaction per cycle for any mix of push and pop while results are taken; the single-port
// storage takes one write or one read per transaction, never both
// sync active-low reset clears head, fill count, occupancy state and output valid;
// storage is not cleared, entries are only read after being written
`include "double_ended_queue_core_defines.svh"
module double_ended_queue_core #(
    parameter int unsigned DEPTH      = 32,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dq_pkg::t_dq_in_item  i_in_item,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dq_pkg::t_dq_out_item o_out_item
);

    // command and status between controller and datapath
    dq_pkg::t_dq_cmd  w_cmd;
    dq_pkg::t_dq_stat w_stat;

    // controller tracks empty / partial / full and decodes each transaction
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath holds the circular storage, pointers and the result register
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_in_item.value),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_stat      (w_stat)
    );

    // a refused push reports full and zero data on the next cycle
    `DQ_ASSERT_NEXT(a_full_refused, i_clk, i_rst_n, w_cmd.load && (w_cmd.status == dq_pkg::ST_FULL), o_out_valid && (o_out_item.status == dq_pkg::ST_FULL) && (o_out_item.pop_value == '0))

    // a refused pop reports empty and zero data on the next cycle
    `DQ_ASSERT_NEXT(a_empty_refused, i_clk, i_rst_n, w_cmd.load && (w_cmd.status == dq_pkg::ST_EMPTY), o_out_valid && (o_out_item.status == dq_pkg::ST_EMPTY) && (o_out_item.pop_value == '0))

    // storage and pointers only move on an accepted, successful transaction
    `DQ_ASSERT_NOW(a_cmd_only_done, i_clk, i_rst_n, w_cmd.push_front || w_cmd.push_rear || w_cmd.pop_front || w_cmd.pop_rear, w_cmd.load && (w_cmd.status == dq_pkg::ST_DONE))

endmodule
